/* design/nrbp_pkg.sv */
package nrbp_pkg;

  // header bytes that open every line
  localparam logic [7:0] HDR_A1 = 8'hAB;
  localparam logic [7:0] HDR_A2 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'hA9;
  localparam logic [7:0] HDR_B2 = 8'hA8;

  // row lanes in the merged result
  localparam int unsigned ROW_A1 = 0;
  localparam int unsigned ROW_A2 = 1;
  localparam int unsigned ROW_B1 = 2;
  localparam int unsigned ROW_B2 = 3;
  localparam int unsigned NUM_ROWS = 4;

  // output beat packing
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned OUT_TDATA_W = 40;

  // work left behind by one raster byte
  typedef struct packed {
    logic hdr;   // line opens with a header beat
    logic dat;   // a packed data beat is due
    logic pad;   // zero beats follow up to the end of the line
  } nrbp_desc_t;

endpackage

/* design/nrbp_lane.sv */
module nrbp_lane import nrbp_pkg::*; #(
  parameter bit HI_NIBBLE   = 1'b1,
  parameter bit SET_NONZERO = 1'b1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       flush_i,
  input  logic [2:0] bit_idx_i,
  input  logic [7:0] pixel_pair_i,
  output logic [7:0] byte_o
);

  logic [7:0] acc_q, acc_d;
  logic [3:0] nib;
  logic       set;

  // pick the nibble and decide whether this row gets the pixel
  assign nib = HI_NIBBLE ? pixel_pair_i[7:4] : pixel_pair_i[3:0];
  assign set = (nib != 4'h0) == SET_NONZERO;

  // msb first within the byte
  assign byte_o = acc_q | (set ? (8'h80 >> bit_idx_i) : 8'h00);

  always_comb begin
    acc_d = acc_q;
    if (take_i) begin
      acc_d = flush_i ? 8'h00 : byte_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

/* design/nrbp_seq.sv */
module nrbp_seq import nrbp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 40,
  parameter int unsigned SLOT_IW    = $clog2(LINE_BYTES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  nrbp_desc_t               desc_i,
  input  logic [SLOT_IW-1:0]       slot_i,
  input  logic [NUM_ROWS-1:0][7:0] bytes_i,
  output logic                     load_ready_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [NUM_ROWS-1:0][7:0] m_bytes_o,
  output logic [SLOT_IW-1:0]       m_slot_o,
  output logic                     m_last_o
);

  localparam logic [SLOT_IW-1:0] LastSlot = SLOT_IW'(LINE_BYTES);

  logic                     hdr_q, hdr_n, dat_q, dat_n, pad_q, pad_n;
  logic [SLOT_IW-1:0]       slot_q, slot_n, slot_inc;
  logic [NUM_ROWS-1:0][7:0] bytes_q;
  logic                     ovld_q;
  logic [NUM_ROWS-1:0][7:0] obytes_q;
  logic [SLOT_IW-1:0]       oslot_q;
  logic                     olast_q;
  logic                     fire, emit, e_last;
  logic [NUM_ROWS-1:0][7:0] e_bytes;
  logic [SLOT_IW-1:0]       e_slot;

  // output register can take a beat
  assign fire     = !ovld_q || m_ready_i;
  assign slot_inc = slot_q + SLOT_IW'(1);

  // merge: header, then the packed beat, then zero padding
  always_comb begin
    emit    = 1'b0;
    e_bytes = '0;
    e_slot  = '0;
    e_last  = 1'b0;
    hdr_n   = hdr_q;
    dat_n   = dat_q;
    pad_n   = pad_q;
    slot_n  = slot_q;
    if (fire) begin
      if (hdr_q) begin
        emit            = 1'b1;
        e_bytes[ROW_A1] = HDR_A1;
        e_bytes[ROW_A2] = HDR_A2;
        e_bytes[ROW_B1] = HDR_B1;
        e_bytes[ROW_B2] = HDR_B2;
        hdr_n           = 1'b0;
      end else if (dat_q) begin
        emit    = 1'b1;
        e_bytes = bytes_q;
        e_slot  = slot_q;
        e_last  = slot_q == LastSlot;
        dat_n   = 1'b0;
      end else if (pad_q) begin
        emit   = 1'b1;
        e_slot = slot_inc;
        e_last = slot_inc == LastSlot;
        slot_n = slot_inc;
        pad_n  = slot_inc != LastSlot;
      end
    end
  end

  // next raster byte may enter once the pending work drains this cycle
  assign load_ready_o = !(hdr_n || dat_n || pad_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= 1'b0;
      dat_q  <= 1'b0;
      pad_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (load_i) begin
        hdr_q <= desc_i.hdr;
        dat_q <= desc_i.dat;
        pad_q <= desc_i.pad;
      end else begin
        hdr_q <= hdr_n;
        dat_q <= dat_n;
        pad_q <= pad_n;
      end
      if (fire) begin
        ovld_q <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q  <= slot_i;
      bytes_q <= bytes_i;
    end else begin
      slot_q <= slot_n;
    end
    if (fire && emit) begin
      obytes_q <= e_bytes;
      oslot_q  <= e_slot;
      olast_q  <= e_last;
    end
  end

  assign m_valid_o = ovld_q;
  assign m_bytes_o = obytes_q;
  assign m_slot_o  = oslot_q;
  assign m_last_o  = olast_q;

endmodule

/* design/nozzle_row_bitplane_packer_top.sv */
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] pixel_pair
// m_axis    out  m_axis_tvalid/tready       tdata: bytes a1,a2,b1,b2, byte_slot; tlast
// cfg       in   cfg_valid/cfg_ready        cfg_data[8:0] pixels_per_line
//
// one raster byte per cycle while the output is not stalled; the header beat holds input back
// only on a one-pixel line, and a line end holds input until its padding beats (LINE_BYTES minus
// the last slot) are sent; the pending-work register in the merge stage causes these holds
// reset: pixels_per_line 320, pixel count and lane accumulators cleared
// a stalled output holds its beat; input is taken while that beat waits if no work is pending
module nozzle_row_bitplane_packer_top import nrbp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] pixel_pair
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] row_a1_byte, [15:8] row_a2_byte, [23:16] row_b1_byte,
  // [31:24] row_b2_byte, [37:32] byte_slot, [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o,   // last_of_line
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [8:0]             cfg_data_i        // pixels_per_line
);

  localparam int unsigned Cap     = LINE_BYTES * 8;
  localparam int unsigned CntW    = $clog2(Cap + 1);
  localparam int unsigned CmpW    = (CntW > 9) ? CntW : 9;
  localparam int unsigned SlotIW  = $clog2(LINE_BYTES + 1);

  logic [8:0]               ppl_q;
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_inc, limit;
  logic [CmpW-1:0]          ppl_w, lim_w;
  logic                     s_fire, flush, line_end;
  logic [SlotIW-1:0]        slot_new, m_slot;
  nrbp_desc_t               desc;
  logic [NUM_ROWS-1:0][7:0] lane_bytes, m_bytes;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q <= 9'd320;
    end else if (cfg_valid_i) begin
      ppl_q <= cfg_data_i;
    end
  end

  // effective pixel limit: zero acts as one, above capacity saturates
  assign ppl_w = CmpW'(ppl_q);
  always_comb begin
    if (ppl_q == 9'd0) begin
      lim_w = CmpW'(1);
    end else if (ppl_w > CmpW'(Cap)) begin
      lim_w = CmpW'(Cap);
    end else begin
      lim_w = ppl_w;
    end
  end
  assign limit = CntW'(lim_w);

  // line position and what this raster byte triggers
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc  = cnt_q + CntW'(1);
  assign line_end = cnt_inc >= limit;
  assign flush    = (cnt_inc[2:0] == 3'd0) || line_end;
  assign slot_new = SlotIW'(cnt_q >> 3) + SlotIW'(1);

  assign desc.hdr = cnt_q == '0;
  assign desc.dat = flush;
  assign desc.pad = line_end && (slot_new != SlotIW'(LINE_BYTES));

  always_comb begin
    cnt_d = cnt_q;
    if (s_fire) begin
      cnt_d = line_end ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // one packing lane per nozzle row
  nrbp_lane #(.HI_NIBBLE(1'b1), .SET_NONZERO(1'b1)) u_lane_a1 (
    .clk_i, .rst_ni, .take_i(s_fire), .flush_i(flush), .bit_idx_i(cnt_q[2:0]),
    .pixel_pair_i(s_axis_tdata_i), .byte_o(lane_bytes[ROW_A1])
  );
  nrbp_lane #(.HI_NIBBLE(1'b0), .SET_NONZERO(1'b1)) u_lane_a2 (
    .clk_i, .rst_ni, .take_i(s_fire), .flush_i(flush), .bit_idx_i(cnt_q[2:0]),
    .pixel_pair_i(s_axis_tdata_i), .byte_o(lane_bytes[ROW_A2])
  );
  nrbp_lane #(.HI_NIBBLE(1'b1), .SET_NONZERO(1'b0)) u_lane_b1 (
    .clk_i, .rst_ni, .take_i(s_fire), .flush_i(flush), .bit_idx_i(cnt_q[2:0]),
    .pixel_pair_i(s_axis_tdata_i), .byte_o(lane_bytes[ROW_B1])
  );
  nrbp_lane #(.HI_NIBBLE(1'b0), .SET_NONZERO(1'b0)) u_lane_b2 (
    .clk_i, .rst_ni, .take_i(s_fire), .flush_i(flush), .bit_idx_i(cnt_q[2:0]),
    .pixel_pair_i(s_axis_tdata_i), .byte_o(lane_bytes[ROW_B2])
  );

  // merge lanes into header, data and padding beats
  nrbp_seq #(.LINE_BYTES(LINE_BYTES), .SLOT_IW(SlotIW)) u_seq (
    .clk_i,
    .rst_ni,
    .load_i      (s_fire),
    .desc_i      (desc),
    .slot_i      (slot_new),
    .bytes_i     (lane_bytes),
    .load_ready_o(s_axis_tready_o),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_bytes_o   (m_bytes),
    .m_slot_o    (m_slot),
    .m_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, SLOT_W'(m_slot), m_bytes[ROW_B2], m_bytes[ROW_B1],
                           m_bytes[ROW_A2], m_bytes[ROW_A1]};

endmodule

/* design/nrbp_checker.sv */
module nrbp_checker import nrbp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 40
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tlast_o
);

  // end of line beat carries the final slot
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[37:32] == SLOT_W'(LINE_BYTES))
    else $error("line end beat on wrong slot");

  // header beat holds the fixed header bytes and is never the line end
  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[37:32] == '0 |->
      m_axis_tdata_o[31:0] == {HDR_B2, HDR_B1, HDR_A2, HDR_A1} && !m_axis_tlast_o)
    else $error("bad header beat");

  // a stalled output beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // refused input means a pending beat shows on the output next cycle
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("input refused with no beat to follow");

endmodule

bind nozzle_row_bitplane_packer_top nrbp_checker #(.LINE_BYTES(LINE_BYTES)) u_nrbp_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tlast_o
);
